// ===== hw/rtl/http_chunked_body_decoder_macros.svh =====
// assertion macros for the chunked body decoder checker
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chbd assertion failed");

// next-cycle implication, disabled during reset
`define CHBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chbd assertion failed");

`endif

// ===== hw/rtl/chbd_pkg.sv =====
// shared types and codes of the chunked body decoder
`timescale 1ns / 1ps
`default_nettype none

package chbd_pkg;

    localparam int TOTAL_W = 32;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_SIZE_LINE  = 3'd0,
        ERR_INCOMPLETE = 3'd1,
        ERR_DATA_CRLF  = 3'd2,
        ERR_OVERFLOW   = 3'd3,
        ERR_HEADER     = 3'd4
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        err_t               code;
        logic [TOTAL_W-1:0] total;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chbd_parser.sv =====
// header skip, chunk size parse and data framing state machine
`timescale 1ns / 1ps
`default_nettype none

module chbd_parser
    import chbd_pkg::*;
#(
    parameter int SIZE_BITS   = 32,
    parameter int LENGTH_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X_LO = 8'h78;
    localparam logic [7:0] CHAR_X_UP = 8'h58;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SIZE,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_WS,
        ST_ZERO,
        ST_DIGITS,
        ST_IGNORE
    } step_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_of(input logic [7:0] b);
        hex_t       h;
        logic [7:0] diff;
        h    = '0;
        diff = '0;
        if (b inside {[8'h30:8'h39]}) begin
            diff = b - 8'h30;
            h.ok = 1'b1;
        end else if (b inside {[8'h61:8'h66]}) begin
            diff = b - 8'h57;
            h.ok = 1'b1;
        end else if (b inside {[8'h41:8'h46]}) begin
            diff = b - 8'h37;
            h.ok = 1'b1;
        end
        h.val = diff[3:0];
        return h;
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [1:0]             hdr_match_reg, hdr_match_next;
    step_t                  step_reg, step_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic                   digit_seen_reg, digit_seen_next;
    logic                   nonempty_reg, nonempty_next;
    logic                   prev_cr_reg, prev_cr_next;
    logic [SIZE_BITS-1:0]   left_reg, left_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    hex_t  hx;
    logic  is_ws;
    logic  left_last;
    logic  emit;
    kind_t emit_kind;
    err_t  emit_code;
    logic  ovf;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_match_next  = hdr_match_reg;
        step_next       = step_reg;
        size_next       = size_reg;
        digit_seen_next = digit_seen_reg;
        nonempty_next   = nonempty_reg;
        prev_cr_next    = prev_cr_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        emit_kind       = KIND_DATA;
        emit_code       = ERR_SIZE_LINE;
        ovf             = 1'b0;
        hx              = hex_of(in_byte);
        is_ws           = (in_byte == CHAR_SP) || (in_byte inside {[CHAR_TAB:CHAR_CR]});
        left_last       = (left_reg[SIZE_BITS-1:1] == '0);

        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (in_byte == (hdr_match_reg[0] ? CHAR_LF : CHAR_CR))
                    begin
                        if (hdr_match_reg == 2'd3)
                        begin
                            hdr_match_next  = 2'd0;
                            phase_next      = PH_SIZE;
                            step_next       = ST_WS;
                            size_next       = '0;
                            digit_seen_next = 1'b0;
                            nonempty_next   = 1'b0;
                            prev_cr_next    = 1'b0;
                        end
                        else
                        begin
                            hdr_match_next = hdr_match_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        hdr_match_next = (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
                    end
                    if (in_final)
                    begin
                        emit = 1'b1;
                        if (phase_next == PH_SIZE)
                        begin
                            emit_kind = KIND_END;
                        end
                        else
                        begin
                            emit_kind = KIND_ERROR;
                            emit_code = ERR_HEADER;
                        end
                    end
                end
                PH_SIZE:
                begin
                    if (in_byte == CHAR_LF)
                    begin
                        emit = 1'b1;
                        if (!nonempty_reg || !prev_cr_reg)
                        begin
                            emit_kind = KIND_ERROR;
                            emit_code = ERR_SIZE_LINE;
                        end
                        else if (!(digit_seen_reg || step_reg == ST_ZERO) || size_reg == '0)
                        begin
                            emit_kind = KIND_END;
                        end
                        else
                        begin
                            // chunk starts, nothing to report unless the stream ends here
                            left_next  = size_reg;
                            phase_next = PH_DATA;
                            emit       = in_final;
                            emit_kind  = KIND_ERROR;
                            emit_code  = ERR_INCOMPLETE;
                        end
                    end
                    else
                    begin
                        nonempty_next = 1'b1;
                        prev_cr_next  = (in_byte == CHAR_CR);
                        case (step_reg)
                            ST_WS:
                            begin
                                if (!is_ws)
                                begin
                                    if (in_byte == CHAR_ZERO)
                                    begin
                                        size_next       = '0;
                                        digit_seen_next = 1'b1;
                                        step_next       = ST_ZERO;
                                    end
                                    else if (hx.ok)
                                    begin
                                        size_next       = SIZE_BITS'(hx.val);
                                        digit_seen_next = 1'b1;
                                        step_next       = ST_DIGITS;
                                    end
                                    else
                                    begin
                                        step_next = ST_IGNORE;
                                    end
                                end
                            end
                            ST_ZERO, ST_DIGITS:
                            begin
                                if (step_reg == ST_ZERO && digit_seen_reg &&
                                    (in_byte == CHAR_X_LO || in_byte == CHAR_X_UP))
                                begin
                                    digit_seen_next = 1'b0;
                                end
                                else
                                begin
                                    digit_seen_next = 1'b1;
                                    if (hx.ok)
                                    begin
                                        step_next = ST_DIGITS;
                                        if (size_reg[SIZE_BITS-1:SIZE_BITS-4] != 4'd0)
                                        begin
                                            ovf = 1'b1;
                                        end
                                        else
                                        begin
                                            size_next = {size_reg[SIZE_BITS-5:0], hx.val};
                                        end
                                    end
                                    else
                                    begin
                                        step_next = ST_IGNORE;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (ovf)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_ERROR;
                            emit_code = ERR_OVERFLOW;
                        end
                        else if (in_final)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_ERROR;
                            emit_code = ERR_SIZE_LINE;
                        end
                    end
                end
                PH_DATA:
                begin
                    emit = 1'b1;
                    if (in_final)
                    begin
                        emit_kind = KIND_ERROR;
                        emit_code = left_last ? ERR_DATA_CRLF : ERR_INCOMPLETE;
                    end
                    else
                    begin
                        emit_kind  = KIND_DATA;
                        count_next = count_reg + LENGTH_BITS'(1);
                        if (left_last)
                        begin
                            left_next  = '0;
                            phase_next = PH_DATA_CR;
                        end
                        else
                        begin
                            left_next = left_reg - SIZE_BITS'(1);
                        end
                    end
                end
                PH_DATA_CR:
                begin
                    if (in_byte != CHAR_CR || in_final)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                        emit_code = ERR_DATA_CRLF;
                    end
                    else
                    begin
                        phase_next = PH_DATA_LF;
                    end
                end
                PH_DATA_LF:
                begin
                    if (in_byte != CHAR_LF)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                        emit_code = ERR_DATA_CRLF;
                    end
                    else
                    begin
                        phase_next      = PH_SIZE;
                        step_next       = ST_WS;
                        size_next       = '0;
                        digit_seen_next = 1'b0;
                        nonempty_next   = 1'b0;
                        prev_cr_next    = 1'b0;
                        emit            = in_final;
                        emit_kind       = KIND_END;
                    end
                end
                default:
                begin
                end
            endcase

            // end or error parks the parser until the final byte
            if (emit && emit_kind != KIND_DATA)
            begin
                phase_next = PH_IDLE;
            end

            // every final byte starts a fresh response
            if (in_final)
            begin
                phase_next      = PH_HEADER;
                hdr_match_next  = 2'd0;
                step_next       = ST_WS;
                size_next       = '0;
                digit_seen_next = 1'b0;
                nonempty_next   = 1'b0;
                prev_cr_next    = 1'b0;
                left_next       = '0;
                count_next      = '0;
            end
        end

        res_valid = emit;
        res.kind  = emit_kind;
        res.data  = (emit_kind == KIND_DATA) ? in_byte : 8'd0;
        res.code  = (emit_kind == KIND_ERROR) ? emit_code : ERR_SIZE_LINE;
        res.total = (emit_kind == KIND_END) ? TOTAL_W'(count_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_match_reg  <= 2'd0;
            step_reg       <= ST_WS;
            size_reg       <= '0;
            digit_seen_reg <= 1'b0;
            nonempty_reg   <= 1'b0;
            prev_cr_reg    <= 1'b0;
            left_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_match_reg  <= hdr_match_next;
            step_reg       <= step_next;
            size_reg       <= size_next;
            digit_seen_reg <= digit_seen_next;
            nonempty_reg   <= nonempty_next;
            prev_cr_reg    <= prev_cr_next;
            left_reg       <= left_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/chbd_out_buf.sv =====
// result register with skid stage for the output channel
`timescale 1ns / 1ps
`default_nettype none

module chbd_out_buf
    import chbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;

    always_comb
    begin
        pop             = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign can_take  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/http_chunked_body_decoder.sv =====
// top level of the http chunked transfer body decoder
// usage:
//   input channel: one byte of the raw response per request (in_byte), with
//   in_final high on the last byte; taken when in_valid and in_ready are high
//   output channel: at most one result per input byte (kind, out_byte,
//   error_code, total_length); taken when out_valid and out_ready are high
//   kind data carries one decoded body byte, kind end the total length,
//   kind error an error code; data already delivered before an error is void
// throughput: one byte per cycle while in_ready is high; each byte is handled in
//   the cycle it is taken by the parser state machine
// output: a result is registered in the result register, or in the skid stage
//   while the result register holds a result that has not been taken
// stall: a result register plus a one-entry skid stage sit in front of the
//   output, so input keeps flowing while one result waits; in_ready drops
//   only once the skid stage is occupied
// reset: rst_n clears the parser to header skipping and empties the output
//   buffer; the final byte of every response also returns the parser there
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder
    import chbd_pkg::*;
#(
    parameter int SIZE_BITS   = 32,
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_final,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  error_code,
    output logic [31:0] total_length
);

    // request handshake on the input side
    logic    in_take;
    // result of the byte taken this cycle, if any
    logic    res_valid;
    result_t res;
    // registered result on the output side
    result_t out_data;

    assign in_take = in_valid && in_ready;

    // byte-level decoding: header skip, size lines, chunk data and the CRLF after each chunk
    chbd_parser #(
        .SIZE_BITS   (SIZE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .in_byte   (in_byte),
        .in_final  (in_final),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register with skid so that a stalled receiver does not stop input at once
    chbd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_take  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign out_byte     = out_data.data;
    assign error_code   = out_data.code;
    assign total_length = out_data.total;

endmodule

`default_nettype wire

// ===== hw/rtl/chbd_checker.sv =====
// port-level checker for the chunked body decoder and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "http_chunked_body_decoder_macros.svh"

module chbd_checker
    import chbd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic [2:0]  error_code,
    input logic [31:0] total_length
);

    // whole result payload as one bus
    logic [44:0] out_bus;
    // result kinds on the output
    logic        data_out;
    logic        error_out;
    logic        kind_known;
    // field contents per kind
    logic        data_clean;
    logic        code_known;
    logic        error_clean;

    assign out_bus     = {kind, out_byte, error_code, total_length};
    assign data_out    = out_valid && (kind == KIND_DATA);
    assign error_out   = out_valid && (kind == KIND_ERROR);
    assign kind_known  = (kind == KIND_DATA) || (kind == KIND_END) || (kind == KIND_ERROR);
    assign data_clean  = (error_code == 3'd0) && (total_length == 32'd0);
    assign code_known  = (error_code == ERR_SIZE_LINE) || (error_code == ERR_INCOMPLETE) ||
                         (error_code == ERR_DATA_CRLF) || (error_code == ERR_OVERFLOW) ||
                         (error_code == ERR_HEADER);
    assign error_clean = code_known && (out_byte == 8'd0) && (total_length == 32'd0);

    // a stalled result holds its payload
    `CHBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))

    // input only backs up while a result is waiting
    `CHBD_ASSERT_NOW(a_ready_backpressure, clk, rst_n, !in_ready, out_valid)

    // data results carry no code and no length
    `CHBD_ASSERT_NOW(a_data_fields, clk, rst_n, data_out, data_clean)

    // error results carry a known code and nothing else
    `CHBD_ASSERT_NOW(a_error_fields, clk, rst_n, error_out, error_clean)

    // only the three result kinds appear
    `CHBD_ASSERT_NOW(a_kind_legal, clk, rst_n, out_valid, kind_known)

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (.*);

`default_nettype wire
